// ----- sv/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg: shared types and helpers of the URL percent decoder
// Character codes, the phase encoding, the queue entry type and the hex
// digit helpers used by the front and back parts.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] PctChar   = 8'h25;
   localparam logic [7:0] PlusChar  = 8'h2B;
   localparam logic [7:0] SpaceChar = 8'h20;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Escape phase, one-hot.
   typedef enum logic [2:0] {
      PhIdle  = 3'b001,
      PhPct   = 3'b010,
      PhDigit = 3'b100
   } phase_type;

   // One accepted item, decoded: one to three output bytes, slot 0 first.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            string_end;
   } group_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end
      return v[3:0];
   endfunction

endpackage

// ----- sv/upd_channels.sv -----
// ----------------------------------------------------------------------------
// upd_channels: valid/ready channels of the URL percent decoder
// Request channel carries raw bytes, response channel carries decoded bytes.
// ----------------------------------------------------------------------------
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       decoded_end;

   modport source (output valid, output out_byte, output run_last,
                   output decoded_end, input ready);
   modport sink   (input valid, input out_byte, input run_last,
                   input decoded_end, output ready);
endinterface

// ----- sv/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front: escape tracking and classification
// Accepts one raw byte per cycle while the queue is not full, tracks the
// escape phase and pushes the bytes each item produces as one queue entry.
// ----------------------------------------------------------------------------
module upd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          in_byte,
   input  logic                string_end,
   input  logic                q_full,
   output logic                q_push,
   output upd_pkg::group_type  q_data
);

   upd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;

   logic       accept;
   logic       byte_hex;
   logic       fresh_opens;
   logic       fresh_emit;
   logic [7:0] fresh_byte;
   upd_pkg::group_type grp;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign byte_hex  = upd_pkg::is_hex(in_byte);

   // Decode with no escape pending.
   assign fresh_opens = (in_byte == upd_pkg::PctChar) && !string_end;
   assign fresh_emit  = !fresh_opens;
   assign fresh_byte  = (in_byte == upd_pkg::PlusChar) ? upd_pkg::SpaceChar : in_byte;

   always_comb begin
      grp            = '0;
      grp.string_end = string_end;
      phase_in       = upd_pkg::PhIdle;
      held_in        = held_ff;
      unique case (phase_ff)
         upd_pkg::PhPct: begin
            if (byte_hex) begin
               if (string_end) begin
                  grp.count    = 2'd2;
                  grp.bytes[0] = upd_pkg::PctChar;
                  grp.bytes[1] = in_byte;
               end else begin
                  phase_in = upd_pkg::PhDigit;
                  held_in  = in_byte;
               end
            end else begin
               grp.count    = 2'd1 + {1'b0, fresh_emit};
               grp.bytes[0] = upd_pkg::PctChar;
               grp.bytes[1] = fresh_byte;
               if (fresh_opens) phase_in = upd_pkg::PhPct;
            end
         end
         upd_pkg::PhDigit: begin
            if (byte_hex) begin
               grp.count    = 2'd1;
               grp.bytes[0] = {upd_pkg::hex_value(held_ff), upd_pkg::hex_value(in_byte)};
            end else begin
               grp.count    = 2'd2 + {1'b0, fresh_emit};
               grp.bytes[0] = upd_pkg::PctChar;
               grp.bytes[1] = held_ff;
               grp.bytes[2] = fresh_byte;
               if (fresh_opens) phase_in = upd_pkg::PhPct;
            end
         end
         default: begin
            grp.count    = {1'b0, fresh_emit};
            grp.bytes[0] = fresh_byte;
            if (fresh_opens) phase_in = upd_pkg::PhPct;
         end
      endcase
      if (string_end) begin
         phase_in = upd_pkg::PhIdle;
         held_in  = 8'h00;
      end
   end

   assign q_push = accept && (grp.count != 2'd0);
   assign q_data = grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PhIdle;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ----- sv/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue: short queue of decoded groups
// Decouples the front from the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module upd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  upd_pkg::group_type  push_data,
   output logic                full,
   input  logic                pop,
   output upd_pkg::group_type  pop_data,
   output logic                empty
);

   upd_pkg::group_type                  slots_ff [upd_pkg::QueueDepth];
   logic [upd_pkg::QueuePtrW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [upd_pkg::QueueCntW-1:0]       count_ff;

   assign full     = (count_ff == upd_pkg::QueueCntW'(upd_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- sv/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back: result serializer
// Walks the bytes of the head group into a registered output stage.
// ----------------------------------------------------------------------------
module upd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  upd_pkg::group_type  q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          out_byte,
   output logic                run_last,
   output logic                decoded_end
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       end_ff;

   logic load;
   logic slot_last;

   assign load      = !q_empty && (!valid_ff || rsp_ready);
   assign slot_last = (idx_ff == q_data.count - 2'd1);
   assign q_pop     = load && slot_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= slot_last ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= q_data.bytes[idx_ff];
         last_ff <= slot_last;
         end_ff  <= slot_last && q_data.string_end;
      end
   end

   assign rsp_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign run_last    = last_ff;
   assign decoded_end = end_ff;

endmodule

// ----- sv/url_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder, '+' as space
//
// req_if takes one raw byte per item with string_end on the last byte of a
// string. rsp_if gives decoded bytes; run_last marks the last byte produced
// by one request item and decoded_end the final byte of a string.
// A '%' and two hex digits become one byte; a malformed or cut-off escape
// emits the '%' and held digit literally and decodes the next byte afresh.
// A byte that completes output is written into the queue when its item is
// accepted and is then loaded into the output register, from which it
// appears on rsp_if; the rsp_if handshake follows once that register is valid.
// Throughput: one item per cycle while each item yields at most one byte
// and rsp_if is ready; a multi-byte item holds the output register per byte,
// and the four-entry queue absorbs such bursts before req_if.ready drops.
// Bytes held inside an escape produce nothing until the escape resolves.
// Reset (synchronous) clears the escape phase, the queue and the output
// register; no item is lost or repeated when rsp_if stalls, since the output
// register holds and the queue backs up into req_if.ready.
// ----------------------------------------------------------------------------
module url_percent_decoder (
   input  logic     clock,
   input  logic     reset,
   upd_req_if.sink  req_if,
   upd_rsp_if.source rsp_if
);

   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   upd_pkg::group_type push_group;
   upd_pkg::group_type head_group;

   // Front: track the escape and turn each item into a group of bytes.
   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .in_byte    (req_if.in_byte),
      .string_end (req_if.string_end),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (push_group)
   );

   // Queue: hold groups while the back drains a burst.
   upd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_group),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_group),
      .empty     (q_empty)
   );

   // Back: advance through the head group one byte per accepted result.
   upd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (head_group),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .out_byte    (rsp_if.out_byte),
      .run_last    (rsp_if.run_last),
      .decoded_end (rsp_if.decoded_end)
   );

endmodule
